@@ rtl/cordic_sine_cosine_macros.svh @@
// assertion macros used by the cordic sine/cosine top level
`ifndef CORDIC_SINE_COSINE_MACROS_SVH
`define CORDIC_SINE_COSINE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet while arst_n is low
`define CSC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cordic sine/cosine assertion failed");

// next-cycle implication, clocked on clk, quiet while arst_n is low
`define CSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cordic sine/cosine assertion failed");

`endif

@@ rtl/csc_pkg.sv @@
// shared constants, types and the arctangent table for the cordic sine/cosine block
`default_nettype none

package csc_pkg;

	// number of micro-rotations, one pipeline stage each (1 to 18)
	localparam int ITERATIONS = 18;

	// field widths
	localparam int ANGLE_W = 16;
	localparam int OUT_W   = 18;

	// folded angle in whole degrees, -90 to 90
	localparam int DEG_W  = 8;
	// fraction bits of the angle accumulator
	localparam int FRAC_W = 16;
	// residual angle, Q16 degrees
	localparam int Z_W    = 25;
	// rotation vector width, leaves headroom over the gain-scaled magnitude
	localparam int XY_W   = 20;

	// angle folding constants
	localparam int MOD_DEG  = 360;
	localparam int HALF_DEG = 180;
	localparam int QUAD_DEG = 90;

	// starting x, compensates the cordic gain
	localparam int GAIN_START = 39797;

	typedef struct packed {
		logic                    valid;
		logic                    flip;
		logic signed [DEG_W-1:0] deg;
	} fold_t;

	typedef struct packed {
		logic                   valid;
		logic                   flip;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
	} rot_t;

	// arctangent of 2^-k in Q16 degrees
	function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] k);
		logic signed [Z_W-1:0] v;
		case (k)
			5'd0:    v = Z_W'(2949120);
			5'd1:    v = Z_W'(1740967);
			5'd2:    v = Z_W'(919879);
			5'd3:    v = Z_W'(466945);
			5'd4:    v = Z_W'(234379);
			5'd5:    v = Z_W'(117304);
			5'd6:    v = Z_W'(58666);
			5'd7:    v = Z_W'(29335);
			5'd8:    v = Z_W'(14668);
			5'd9:    v = Z_W'(7334);
			5'd10:   v = Z_W'(3667);
			5'd11:   v = Z_W'(1833);
			5'd12:   v = Z_W'(917);
			5'd13:   v = Z_W'(458);
			5'd14:   v = Z_W'(229);
			5'd15:   v = Z_W'(115);
			5'd16:   v = Z_W'(57);
			5'd17:   v = Z_W'(29);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/csc_fold.sv @@
// three-stage angle fold: modulo 360 toward zero, then into -90..90 with a flip flag
`default_nettype none

module csc_fold (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid,
	input  logic signed [csc_pkg::ANGLE_W-1:0]  angle_degrees,
	output csc_pkg::fold_t                      fold
);
	import csc_pkg::*;

	// stage 1: add +-180 and take the magnitude
	logic                      neg;
	logic signed [ANGLE_W:0]   sum;
	logic        [ANGLE_W:0]   sum_neg;
	logic        [ANGLE_W-1:0] mag;

	logic                      valid_s1;
	logic                      neg_s1;
	logic        [ANGLE_W-1:0] mag_s1;

	assign neg     = angle_degrees[ANGLE_W-1];
	assign sum     = {angle_degrees[ANGLE_W-1], angle_degrees}
	               + (neg ? -(ANGLE_W+1)'(HALF_DEG) : (ANGLE_W+1)'(HALF_DEG));
	assign sum_neg = -sum;
	// sum has the sign of the angle
	assign mag     = neg ? sum_neg[ANGLE_W-1:0] : sum[ANGLE_W-1:0];

	// stage 2: restoring remainder, upper four quotient bits
	logic [ANGLE_W-1:0] rem_hi;
	logic               valid_s2;
	logic               neg_s2;
	logic [11:0]        rem_s2;

	always_comb begin
		rem_hi = mag_s1;
		for (int j = 6; j >= 3; j--) begin
			if (rem_hi >= ANGLE_W'(MOD_DEG << j)) begin
				rem_hi = rem_hi - ANGLE_W'(MOD_DEG << j);
			end
		end
	end

	// stage 3: lower three quotient bits, restore the sign, fold to -90..90
	logic [11:0]             rem_lo;
	logic [8:0]              rem9;
	logic signed [9:0]       deg_half;
	logic signed [9:0]       deg_quad;
	logic                    flip_next;

	logic                    valid_s3;
	logic                    flip_s3;
	logic signed [DEG_W-1:0] deg_s3;

	always_comb begin
		rem_lo = rem_s2;
		for (int j = 2; j >= 0; j--) begin
			if (rem_lo >= 12'(MOD_DEG << j)) begin
				rem_lo = rem_lo - 12'(MOD_DEG << j);
			end
		end
		rem9 = rem_lo[8:0];
		// signed remainder minus the same half turn
		if (neg_s2) begin
			deg_half = 10'(HALF_DEG) - signed'({1'b0, rem9});
		end else begin
			deg_half = signed'({1'b0, rem9}) - 10'(HALF_DEG);
		end
		// move by half a turn toward zero outside the right half plane
		if (deg_half > 10'sd90) begin
			deg_quad  = deg_half - 10'(HALF_DEG);
			flip_next = 1'b1;
		end else if (deg_half < -10'(QUAD_DEG)) begin
			deg_quad  = deg_half + 10'(HALF_DEG);
			flip_next = 1'b1;
		end else begin
			deg_quad  = deg_half;
			flip_next = 1'b0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= neg;
			mag_s1  <= mag;
			neg_s2  <= neg_s1;
			rem_s2  <= rem_hi[11:0];
			flip_s3 <= flip_next;
			deg_s3  <= deg_quad[DEG_W-1:0];
		end
	end

	assign fold.valid = valid_s3;
	assign fold.flip  = flip_s3;
	assign fold.deg   = deg_s3;

endmodule

`default_nettype wire

@@ rtl/csc_rotate.sv @@
// pipelined rotation-mode cordic, one micro-rotation per stage
`default_nettype none

module csc_rotate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  csc_pkg::fold_t fold,
	output csc_pkg::rot_t  rot
);
	import csc_pkg::*;

	logic                   v_s    [ITERATIONS];
	logic                   flip_s [ITERATIONS];
	logic signed [XY_W-1:0] x_s    [ITERATIONS];
	logic signed [XY_W-1:0] y_s    [ITERATIONS];
	logic signed [Z_W-1:0]  z_s    [ITERATIONS];

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
		logic                   v_in;
		logic                   f_in;
		logic signed [XY_W-1:0] x_in;
		logic signed [XY_W-1:0] y_in;
		logic signed [Z_W-1:0]  z_in;
		logic signed [XY_W-1:0] x_sh;
		logic signed [XY_W-1:0] y_sh;
		logic                   up;

		// stage inputs: the folded angle for the first stage, else the stage before
		if (k == 0) begin : g_first
			assign v_in = fold.valid;
			assign f_in = fold.flip;
			assign x_in = XY_W'(GAIN_START);
			assign y_in = '0;
			assign z_in = {{(Z_W-DEG_W-FRAC_W){fold.deg[DEG_W-1]}}, fold.deg,
			               {FRAC_W{1'b0}}};
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign f_in = flip_s[k-1];
			assign x_in = x_s[k-1];
			assign y_in = y_s[k-1];
			assign z_in = z_s[k-1];
		end

		// residual above zero rotates counterclockwise, zero or below clockwise
		assign up   = !z_in[Z_W-1] && (z_in != '0);
		assign x_sh = x_in >>> k;
		assign y_sh = y_in >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[k] <= f_in;
				if (up) begin
					x_s[k] <= x_in - y_sh;
					y_s[k] <= y_in + x_sh;
					z_s[k] <= z_in - atan_q16(5'(k));
				end else begin
					x_s[k] <= x_in + y_sh;
					y_s[k] <= y_in - x_sh;
					z_s[k] <= z_in + atan_q16(5'(k));
				end
			end
		end
	end

	assign rot.valid = v_s[ITERATIONS-1];
	assign rot.flip  = flip_s[ITERATIONS-1];
	assign rot.x     = x_s[ITERATIONS-1];
	assign rot.y     = y_s[ITERATIONS-1];

endmodule

`default_nettype wire

@@ rtl/cordic_sine_cosine.sv @@
// top level of the pipelined cordic sine/cosine generator
//
// angle channel: angle_valid, angle_stall, angle_degrees (signed whole degrees).
// result channel: result_valid, result_stall, cos_q16 and sin_q16 (signed Q16).
// a request moves when valid is high and stall is low at a rising edge of clk.
// throughput is one request per cycle while angle_stall is low: three
// angle-fold stages feed one cordic stage per micro-rotation (18), then an
// output register, and each result passes through them in that order.
// when result_stall is held, the finished result waits in the output register
// and one more request lands in a skid register; angle_stall then rises and
// the whole pipeline holds until the skid drains. nothing is lost or repeated.
// arst_n clears every valid bit, so both channels come up empty with
// angle_stall low.
`default_nettype none
`include "cordic_sine_cosine_macros.svh"

module cordic_sine_cosine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                angle_valid,
	output logic                                angle_stall,
	input  logic signed [csc_pkg::ANGLE_W-1:0]  angle_degrees,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [csc_pkg::OUT_W-1:0]    cos_q16,
	output logic signed [csc_pkg::OUT_W-1:0]    sin_q16
);
	import csc_pkg::*;

	logic  en;
	fold_t fold;
	rot_t  rot;

	logic                    result_valid_q;
	logic signed [OUT_W-1:0] cos_q;
	logic signed [OUT_W-1:0] sin_q;
	logic                    skid_valid_q;
	logic signed [OUT_W-1:0] skid_cos_q;
	logic signed [OUT_W-1:0] skid_sin_q;

	logic signed [XY_W-1:0]  x_fix;
	logic signed [XY_W-1:0]  y_fix;

	// the pipeline moves whenever the skid register is free
	assign en          = !skid_valid_q;
	assign angle_stall = skid_valid_q;

	csc_fold u_fold (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.valid         (angle_valid),
		.angle_degrees (angle_degrees),
		.fold          (fold)
	);

	csc_rotate u_rotate (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.fold   (fold),
		.rot    (rot)
	);

	// undo the half-turn fold
	assign x_fix = rot.flip ? -rot.x : rot.x;
	assign y_fix = rot.flip ? -rot.y : rot.y;

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (skid_valid_q) begin
			if (!result_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (rot.valid) begin
			if (result_valid_q && result_stall) begin
				skid_valid_q <= 1'b1;
			end else begin
				result_valid_q <= 1'b1;
			end
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!result_stall) begin
				cos_q <= skid_cos_q;
				sin_q <= skid_sin_q;
			end
		end else if (rot.valid) begin
			if (result_valid_q && result_stall) begin
				skid_cos_q <= x_fix[OUT_W-1:0];
				skid_sin_q <= y_fix[OUT_W-1:0];
			end else begin
				cos_q <= x_fix[OUT_W-1:0];
				sin_q <= y_fix[OUT_W-1:0];
			end
		end
	end

	assign result_valid = result_valid_q;
	assign cos_q16      = cos_q;
	assign sin_q16      = sin_q;

	// checks on the output buffering and the fold
	`CSC_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, result_valid_q)
	`CSC_ASSERT_NEXT(a_skid_fill, result_valid_q && result_stall && !skid_valid_q && rot.valid, skid_valid_q)
	`CSC_ASSERT_NEXT(a_skid_drain, skid_valid_q && !result_stall, result_valid_q && !skid_valid_q)
	`CSC_ASSERT_IMPL(a_fold_range, fold.valid, fold.deg <= 8'sd90 && fold.deg >= -8'sd90)

endmodule

`default_nettype wire

@@ sim/cordic_sine_cosine_test.sv @@
// self-checking testbench for the pipelined cordic sine/cosine generator
`timescale 1ns / 100ps

module cordic_sine_cosine_test;

	import csc_pkg::*;

	// one expected result: cosine and sine in Q16
	typedef struct packed {
		logic signed [OUT_W-1:0] cos_v;
		logic signed [OUT_W-1:0] sin_v;
	} trig_t;

	localparam int ARCTAN_LEN  = 18;
	localparam int RANDOM_REQS = 1650;
	localparam int DIRECTED_N  = 24;
	localparam int HOLD_AT     = 1500;
	localparam int HOLD_LEN    = 300;
	localparam int DRAIN_WAIT  = 40;

	// arctangent of 2^-k in Q16 degrees
	localparam int ARCTAN_Q16 [ARCTAN_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29
	};

	// directed angles; no result here is simple enough to type in by hand,
	// so every row goes through the predictor
	localparam logic signed [ANGLE_W-1:0] DIRECTED [DIRECTED_N] = '{
		16'sd0,                      // zero
		16'sd90, -16'sd90,           // exactly a quarter turn, left unmoved
		16'sd91, -16'sd91,           // just past a quarter turn, moved and negated
		16'sd89, -16'sd89,
		16'sd180, -16'sd180,         // half turn folds to the other side then to zero
		16'sd540, -16'sd540,         // odd multiples of half a turn
		16'sd360, -16'sd360,         // whole turns
		16'sd179, -16'sd179,
		16'sd270, -16'sd270,
		16'sd45, -16'sd45,
		16'sd1, -16'sd1,
		16'sd32767,                  // widest positive angle
		-16'sd32768,                 // widest negative angle
		16'sd32580                   // large multiple of 180 (181 * 180)
	};

	logic                       clk;
	logic                       arst_n;
	logic                       angle_valid;
	logic                       angle_stall;
	logic signed [ANGLE_W-1:0]  angle_degrees;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [OUT_W-1:0]    cos_q16;
	logic signed [OUT_W-1:0]    sin_q16;

	trig_t pending_trig [$];
	int    mismatch_count;
	bit    calm;

	cordic_sine_cosine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.angle_valid   (angle_valid),
		.angle_stall   (angle_stall),
		.angle_degrees (angle_degrees),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.cos_q16       (cos_q16),
		.sin_q16       (sin_q16)
	);

	// fold the angle, then run the rotation-mode micro-rotations
	function automatic trig_t rotate_angle(input logic signed [ANGLE_W-1:0] a);
		int     deg;
		int     half;
		int     n;
		bit     flip;
		longint target;
		longint acc;
		longint x;
		longint y;
		longint nx;
		trig_t  r;
		deg  = a;
		half = (deg < 0) ? -180 : 180;
		flip = 1'b0;
		n    = (ITERATIONS > ARCTAN_LEN) ? ARCTAN_LEN : ITERATIONS;
		// fold into -180..180, remainder truncates toward zero
		deg = ((deg + half) % 360) - half;
		// fold into -90..90
		if (deg > 90) begin
			deg -= 180;
			flip = 1'b1;
		end else if (deg < -90) begin
			deg += 180;
			flip = 1'b1;
		end
		target = longint'(deg) * 65536;
		acc    = 0;
		x      = GAIN_START;
		y      = 0;
		// ties rotate clockwise
		for (int k = 0; k < n; k++) begin
			if (target > acc) begin
				nx  = x - (y >>> k);
				y   = y + (x >>> k);
				acc += ARCTAN_Q16[k];
			end else begin
				nx  = x + (y >>> k);
				y   = y - (x >>> k);
				acc -= ARCTAN_Q16[k];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		r.cos_v = x[OUT_W-1:0];
		r.sin_v = y[OUT_W-1:0];
		return r;
	endfunction

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// safety limit on run length
	initial begin
		#2ms;
		$display("%0t: timeout, %0d results still pending", $time, pending_trig.size());
		$display("*** FAILED ***");
		$finish;
	end

	// record accepted requests and check accepted results
	always @(posedge clk) begin
		trig_t want;
		if (arst_n) begin
			if (angle_valid && !angle_stall)
				pending_trig.push_back(rotate_angle(angle_degrees));
			if (result_valid && !result_stall) begin
				if (pending_trig.size() == 0) begin
					$display("%0t: unexpected result, got cos %0d sin %0d",
						$time, cos_q16, sin_q16);
					mismatch_count++;
				end else begin
					want = pending_trig.pop_front();
					if (cos_q16 !== want.cos_v) begin
						$display("%0t: cos mismatch, expected %0d, actual %0d",
							$time, want.cos_v, cos_q16);
						mismatch_count++;
					end
					if (sin_q16 !== want.sin_v) begin
						$display("%0t: sin mismatch, expected %0d, actual %0d",
							$time, want.sin_v, sin_q16);
						mismatch_count++;
					end
				end
			end
		end
	end

	// result side: random stalls, one long hold-off to back up the pipeline
	initial begin
		int cycle_cnt;
		cycle_cnt    = 0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle_cnt++;
			if (cycle_cnt == HOLD_AT) begin
				result_stall <= 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				cycle_cnt += HOLD_LEN;
			end else begin
				result_stall <= !calm && ($urandom_range(99) < 36);
			end
		end
	end

	// offer one angle request, with random idle cycles first; called at a falling edge
	task automatic offer_angle(input logic signed [ANGLE_W-1:0] a);
		while (!calm && ($urandom_range(99) < 36)) begin
			angle_valid <= 1'b0;
			@(negedge clk);
		end
		angle_valid   <= 1'b1;
		angle_degrees <= a;
		do @(posedge clk); while (angle_stall);
		@(negedge clk);
	endtask

	// pick a random angle, weighted toward the fold boundaries
	function automatic logic signed [ANGLE_W-1:0] pick_angle();
		int sel;
		int v;
		sel = $urandom_range(99);
		if (sel < 50)
			v = $urandom_range(16'hFFFF);
		else if (sel < 75)
			v = int'($urandom_range(800)) - 400;
		else if (sel < 90)
			v = (int'($urandom_range(728)) - 364) * 90 + int'($urandom_range(2)) - 1;
		else if (sel < 95)
			v = 32767 - int'($urandom_range(15));
		else
			v = -32768 + int'($urandom_range(15));
		return v[ANGLE_W-1:0];
	endfunction

	// reset, directed table, random requests, drain
	initial begin
		int waited;
		mismatch_count = 0;
		calm           = 1'b0;
		arst_n         = 1'b0;
		angle_valid    = 1'b0;
		angle_degrees  = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			offer_angle(DIRECTED[i]);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			// a stretch with no idling on either side
			calm = (i >= 700) && (i < 1000);
			offer_angle(pick_angle());
		end
		calm = 1'b0;
		angle_valid <= 1'b0;

		while (pending_trig.size() != 0) @(negedge clk);
		// watch a while longer for stray results
		waited = 0;
		while (waited < DRAIN_WAIT) begin
			@(negedge clk);
			waited++;
		end

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_fold.sv
rtl/csc_rotate.sv
rtl/cordic_sine_cosine.sv
sim/cordic_sine_cosine_test.sv
